FILE: sv/sssp_pkg.sv
// Package for the shortest path unit: operation codes, controller state type,
// command/status structs and shared constants. No dependencies.
`timescale 1ns / 1ps
package sssp_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [19:0] DIST_INF  = 20'd999999;
  localparam logic [6:0]  PRED_NONE = 7'h7F;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_INIT,
    ST_SCAN,
    ST_RELAX_RD,
    ST_RELAX,
    ST_EMIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input beat
    logic clr_wr;    // write no-edge at the sweep index
    logic add_rd;    // read the forward entry of the new edge
    logic add_wr;    // write back both directed entries
    logic init_wr;   // initialize working entry at the sweep index
    logic scan_step; // compare one node during the minimum search
    logic scan_done; // mark the chosen node visited
    logic relax_rd;  // issue read of one edge of the chosen node
    logic relax_wr;  // apply relaxation of the edge read last cycle
    logic emit;      // present one result
    logic cnt_clr;   // reset the sweep index
    logic cnt_inc;   // advance the sweep index
    logic iter_clr;  // reset the outer iteration counter
    logic iter_inc;  // advance the outer iteration counter
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] op;
    logic       add_ok;     // both endpoints in range
    logic       start_ok;   // start node below the active count
    logic       cnt_last;   // sweep index at its final value
    logic       prev_last;  // index of the edge read last cycle is the final node
    logic       clr_last;   // clear sweep at its final entry
    logic       iter_last;  // outer iterations finished
    logic       found;      // minimum search found a node
  } sts_t;

endpackage

FILE: sv/single_source_shortest_path_unit.sv
// Top level of the shortest path unit: controller, datapath, config register.
// Depends on sssp_pkg, sssp_ctrl, sssp_dp.
//
//  channel   handshake            payload
//  input     start & !busy        operation, src/dest node, weight, start node
//  config    cfg_valid & ready    node_count (7 bits)
//  result    result_valid_o       node_index, distance, predecessor, last
//
// Clear writes one edge store entry per cycle over the whole store, padded to
// the square of the next power of two when Nodes is not a power of two.
// Add edge reads the forward entry, then writes it and the reverse entry.
// Run: per visited node a scan of the working store, a search step and a sweep of
// the edge store. After reset the unit stays busy while it empties the edge store,
// one entry per cycle. The receiver cannot stall: results come one per cycle.
`timescale 1ns / 1ps
module single_source_shortest_path_unit #(
  parameter int Nodes = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data_i,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  src_node_i,
  input  logic [5:0]  dest_node_i,
  input  logic [11:0] edge_weight_i,
  input  logic [5:0]  start_node_i,
  output logic        result_valid_o,
  output logic [5:0]  node_index_o,
  output logic [19:0] distance_o,
  output logic signed [6:0] predecessor_o,
  output logic        last_o
);

  sssp_pkg::cmd_t cmd;
  sssp_pkg::sts_t sts;
  logic [6:0] node_count_q;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd32;
    end else if (cfg_valid) begin
      node_count_q <= cfg_data_i;
    end
  end

  sssp_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  sssp_dp #(.Nodes(Nodes)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .node_count_i  (node_count_q),
    .operation_i   (operation_i),
    .src_node_i    (src_node_i),
    .dest_node_i   (dest_node_i),
    .edge_weight_i (edge_weight_i),
    .start_node_i  (start_node_i),
    .result_valid_o(result_valid_o),
    .node_index_o  (node_index_o),
    .distance_o    (distance_o),
    .predecessor_o (predecessor_o),
    .last_o        (last_o)
  );

endmodule

FILE: sv/sssp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/sssp_ctrl.sv
// Controller state machine for the shortest path unit.
// Depends on sssp_pkg.
`timescale 1ns / 1ps
module sssp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sssp_pkg::sts_t sts_i,
  output sssp_pkg::cmd_t cmd_o
);

  sssp_pkg::state_e state_q, state_d;

  // State register; reset starts with a sweep that empties the edge store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      sssp_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          cmd_o.iter_clr = 1'b1;
          state_d = sssp_pkg::ST_INIT;
        end
      end
      sssp_pkg::ST_INIT: begin
        // First cycle after the beat: decode the operation; runs initialize.
        case (sts_i.op)
          sssp_pkg::OP_CLEAR: state_d = sssp_pkg::ST_CLEAR;
          sssp_pkg::OP_ADD: begin
            if (sts_i.add_ok) begin
              cmd_o.add_rd = 1'b1;
              state_d = sssp_pkg::ST_ADD_RD;
            end else begin
              state_d = sssp_pkg::ST_IDLE;
            end
          end
          sssp_pkg::OP_RUN: begin
            cmd_o.init_wr = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            if (sts_i.cnt_last) begin
              cmd_o.cnt_clr = 1'b1;
              state_d = sts_i.start_ok ? sssp_pkg::ST_SCAN : sssp_pkg::ST_EMIT;
            end
          end
          default: state_d = sssp_pkg::ST_IDLE;
        endcase
      end
      sssp_pkg::ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clr_last) begin
          state_d = sssp_pkg::ST_IDLE;
        end
      end
      sssp_pkg::ST_ADD_RD: begin
        // Hold the read address so the entry is still on the read port.
        cmd_o.add_rd = 1'b1;
        state_d = sssp_pkg::ST_ADD_WR;
      end
      sssp_pkg::ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d = sssp_pkg::ST_IDLE;
      end
      sssp_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = sssp_pkg::ST_RELAX_RD;
        end
      end
      sssp_pkg::ST_RELAX_RD: begin
        // Search result is settled here.
        if (!sts_i.found || sts_i.iter_last) begin
          state_d = sssp_pkg::ST_EMIT;
        end else begin
          cmd_o.scan_done = 1'b1;
          cmd_o.relax_rd  = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          state_d = sssp_pkg::ST_RELAX;
        end
      end
      sssp_pkg::ST_RELAX: begin
        // Edge data for the previous index is available; the sweep ends once
        // the final node's edge has been applied.
        cmd_o.relax_wr = 1'b1;
        if (sts_i.prev_last) begin
          cmd_o.cnt_clr  = 1'b1;
          cmd_o.iter_inc = 1'b1;
          state_d = sssp_pkg::ST_SCAN;
        end else begin
          cmd_o.relax_rd = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
        end
      end
      sssp_pkg::ST_EMIT: begin
        cmd_o.emit    = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = sssp_pkg::ST_IDLE;
        end
      end
      default: state_d = sssp_pkg::ST_IDLE;
    endcase
  end

  // A run never reports before a beat was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy)
    else $error("emit while idle");
  // Only one memory access kind per cycle toward the edge store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_wr, cmd_o.add_rd, cmd_o.add_wr, cmd_o.relax_rd}))
    else $error("edge store conflict");
  // A loaded beat always leaves idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q != sssp_pkg::ST_IDLE)
    else $error("beat lost");

endmodule

FILE: sv/sssp_dp.sv
// Datapath for the shortest path unit: edge store, working arrays, counters.
// Depends on sssp_pkg and sssp_ram.
`timescale 1ns / 1ps
module sssp_dp #(
  parameter int Nodes = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sssp_pkg::cmd_t cmd_i,
  output sssp_pkg::sts_t sts_o,
  input  logic [6:0]    node_count_i,
  input  logic [1:0]    operation_i,
  input  logic [5:0]    src_node_i,
  input  logic [5:0]    dest_node_i,
  input  logic [11:0]   edge_weight_i,
  input  logic [5:0]    start_node_i,
  output logic          result_valid_o,
  output logic [5:0]    node_index_o,
  output logic [19:0]   distance_o,
  output logic signed [6:0] predecessor_o,
  output logic          last_o
);

  // The edge store is addressed by the node pair, so it spans a power of two.
  localparam int IdxW  = $clog2(Nodes);
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = 1 << AddrW;
  localparam int CntW  = AddrW + 1;

  // Captured beat and active count.
  logic [1:0]  op_q;
  logic [5:0]  src_q, dst_q, start_q;
  logic [11:0] w_q;
  logic [6:0]  n_q;
  logic [IdxW-1:0] n_last;
  logic [6:0] n_clamp;

  always_comb begin
    n_clamp = node_count_i;
    if (n_clamp == 7'd0) n_clamp = 7'd1;
    if (n_clamp > 7'(Nodes)) n_clamp = 7'(Nodes);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      src_q   <= src_node_i;
      dst_q   <= dest_node_i;
      w_q     <= edge_weight_i;
      start_q <= start_node_i;
      n_q     <= n_clamp;
    end
  end
  assign n_last = IdxW'(n_q - 7'd1);

  // Sweep index and outer iteration count.
  logic [CntW-1:0] cnt_q;
  logic [6:0]      iter_q;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_d1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      iter_q <= '0;
    end else begin
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.iter_clr) iter_q <= '0;
      else if (cmd_i.iter_inc) iter_q <= iter_q + 7'd1;
    end
  end
  assign idx = cnt_q[IdxW-1:0];
  always_ff @(posedge clk_i) idx_d1_q <= idx;

  // Working store: per-node distance, predecessor and visited mark.
  logic [19:0] dist_q [Nodes];
  logic [6:0]  pred_q [Nodes];
  logic [Nodes-1:0] vis_q;

  // Minimum search state.
  logic [19:0]     least_q;
  logic [IdxW-1:0] u_q;
  logic            found_q;
  logic [19:0]     du_q;

  // Edge store, one directed entry per address.
  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [12:0]     wdata, rdata;
  logic            add_hold_q;
  logic [12:0]     fwd_q;
  logic            add_phase_q;

  sssp_ram #(.Width(13), .Depth(Depth)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The two directed entries of an added edge share one read address and
  // weight check; the reverse entry is the same pair swapped.
  logic [AddrW-1:0] a_fwd, a_rev;
  logic [12:0] add_val;
  assign a_fwd = {src_q[IdxW-1:0], dst_q[IdxW-1:0]};
  assign a_rev = {dst_q[IdxW-1:0], src_q[IdxW-1:0]};

  function automatic logic [12:0] keep_min(input logic [12:0] cur, input logic [11:0] w);
    logic [12:0] r;
    r = cur;
    if (!cur[12] || w < cur[11:0]) r = {1'b1, w};
    return r;
  endfunction

  // Symmetric store: forward and reverse always hold the same value, so one
  // read of the forward entry decides both writes. Reverse follows forward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_phase_q <= 1'b0;
    end else begin
      add_phase_q <= cmd_i.add_wr;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) fwd_q <= keep_min(rdata, w_q);
  end
  assign add_hold_q = add_phase_q;
  assign add_val = keep_min(rdata, w_q);

  always_comb begin
    we    = 1'b0;
    waddr = a_fwd;
    wdata = add_val;
    raddr = {u_q, idx};
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = cnt_q[AddrW-1:0];
      wdata = '0;
    end else if (cmd_i.add_wr) begin
      we    = 1'b1;
    end else if (add_hold_q) begin
      we    = 1'b1;
      waddr = a_rev;
      wdata = fwd_q;
    end
    if (cmd_i.add_rd) raddr = a_fwd;
  end

  // Minimum search and relaxation.
  logic [19:0] cand;
  assign cand = du_q + 20'(rdata[11:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      dist_q[idx] <= (6'(idx) == start_q) ? 20'd0 : sssp_pkg::DIST_INF;
      pred_q[idx] <= sssp_pkg::PRED_NONE;
    end
    if (cmd_i.scan_step && idx == '0) begin
      least_q <= (!vis_q[0] && dist_q[0] < sssp_pkg::DIST_INF) ? dist_q[0]
                 : sssp_pkg::DIST_INF;
      u_q     <= '0;
    end else if (cmd_i.scan_step && !vis_q[idx] && dist_q[idx] < least_q) begin
      least_q <= dist_q[idx];
      u_q     <= idx;
    end
    if (cmd_i.scan_done) du_q <= least_q;
    if (cmd_i.relax_wr && rdata[12] && !vis_q[idx_d1_q] && cand < dist_q[idx_d1_q]) begin
      dist_q[idx_d1_q] <= cand;
      pred_q[idx_d1_q] <= {1'b0, 6'(u_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.init_wr) vis_q[idx] <= 1'b0;
      if (cmd_i.scan_step && idx == '0) begin
        found_q <= !vis_q[0] && dist_q[0] < sssp_pkg::DIST_INF;
      end else if (cmd_i.scan_step && !vis_q[idx] && dist_q[idx] < least_q) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_done) vis_q[u_q] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      node_index_o  <= 6'(idx);
      distance_o    <= dist_q[idx];
      predecessor_o <= pred_q[idx];
      last_o        <= (idx == n_last);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.op        = op_q;
    sts_o.add_ok    = (32'(src_q) < Nodes) && (32'(dst_q) < Nodes);
    sts_o.start_ok  = 7'(start_q) < n_q;
    sts_o.cnt_last  = (idx == n_last);
    sts_o.prev_last = (idx_d1_q == n_last);
    sts_o.clr_last  = (cnt_q[AddrW-1:0] == AddrW'(Depth - 1));
    sts_o.iter_last = (iter_q == n_q - 7'd1);
    sts_o.found     = found_q;
  end

  // The reverse write always follows the forward write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |=> add_phase_q)
    else $error("reverse edge write missing");
  // A node is only marked visited when the search found one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_done |-> found_q)
    else $error("visiting with no node found");
  // Results stay inside the active node range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 7'(node_index_o) < n_q)
    else $error("result index out of range");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for single_source_shortest_path_unit: directed table, node count
// extremes, then random edge loads, runs and clears, all checked against a behavioral
// shortest path predictor. Depends on sssp_pkg and the unit's RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int Nodes = 32;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic {EXP_MODEL, EXP_ISOLATED} exp_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [11:0] weight;
    logic [5:0]  start_node;
    exp_kind_e   kind;
  } cmd_row_t;

  typedef struct packed {
    logic [5:0]  node;
    logic [19:0] distance;
    logic [6:0]  pred;
    logic        last;
  } path_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data_i = '0;
  logic [1:0]  operation_i = sssp_pkg::OP_CLEAR;
  logic [5:0]  src_node_i = '0;
  logic [5:0]  dest_node_i = '0;
  logic [11:0] edge_weight_i = '0;
  logic [5:0]  start_node_i = '0;
  logic        result_valid_o;
  logic [5:0]  node_index_o;
  logic [19:0] distance_o;
  logic signed [6:0] predecessor_o;
  logic        last_o;

  // Predictor state: edge store and the node count register.
  logic [12:0] edge_store [Nodes*Nodes];
  logic [6:0]  node_count_q = 7'd32;
  path_res_t   expected_paths [$];
  int          mismatches = 0;

  single_source_shortest_path_unit #(.Nodes(Nodes)) i_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid, .cfg_ready, .cfg_data_i,
    .operation_i, .src_node_i, .dest_node_i, .edge_weight_i, .start_node_i,
    .result_valid_o, .node_index_o, .distance_o, .predecessor_o, .last_o
  );

  always #4 clk_i = ~clk_i;

  function automatic int active_count();
    if (node_count_q == 0) return 1;
    if (node_count_q > Nodes) return Nodes;
    return node_count_q;
  endfunction

  function automatic void store_edge(int a, int b, logic [11:0] w);
    if (!edge_store[a*Nodes+b][12] || w < edge_store[a*Nodes+b][11:0]) begin
      edge_store[a*Nodes+b] = {1'b1, w};
    end
  endfunction

  // Dense Dijkstra over the first n nodes; pushes one result per node.
  function automatic void predict_paths(int src);
    int n, u, least, cand;
    bit found;
    int dist_v [Nodes];
    logic [6:0] pred [Nodes];
    bit seen [Nodes];
    n = active_count();
    for (int i = 0; i < n; i++) begin
      dist_v[i] = sssp_pkg::DIST_INF;
      pred[i] = sssp_pkg::PRED_NONE;
      seen[i] = 1'b0;
    end
    if (src < n) begin
      dist_v[src] = 0;
      for (int i = 0; i + 1 < n; i++) begin
        found = 1'b0;
        u = 0;
        least = sssp_pkg::DIST_INF;
        for (int j = 0; j < n; j++) begin
          if (!seen[j] && dist_v[j] < least) begin
            u = j;
            least = dist_v[j];
            found = 1'b1;
          end
        end
        if (!found) break;
        seen[u] = 1'b1;
        for (int v = 0; v < n; v++) begin
          if (edge_store[u*Nodes+v][12] && !seen[v]) begin
            cand = dist_v[u] + edge_store[u*Nodes+v][11:0];
            if (cand < dist_v[v]) begin
              dist_v[v] = cand;
              pred[v] = u[6:0];
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      expected_paths.push_back({i[5:0], dist_v[i][19:0], pred[i], i == n - 1});
    end
  endfunction

  // Updates the predictor for one accepted command beat.
  function automatic void apply_command(cmd_row_t c);
    int n;
    case (c.op)
      sssp_pkg::OP_CLEAR: begin
        foreach (edge_store[i]) edge_store[i] = '0;
      end
      sssp_pkg::OP_ADD: begin
        if (c.src < Nodes && c.dst < Nodes) begin
          store_edge(c.src, c.dst, c.weight);
          store_edge(c.dst, c.src, c.weight);
        end
      end
      sssp_pkg::OP_RUN: begin
        if (c.kind == EXP_MODEL) begin
          predict_paths(c.start_node);
        end else begin
          // Nothing reachable: only the start node itself, if in range, is at zero.
          n = active_count();
          for (int i = 0; i < n; i++) begin
            expected_paths.push_back({i[5:0],
                                      (i == c.start_node) ? 20'd0 : sssp_pkg::DIST_INF,
                                      sssp_pkg::PRED_NONE, i == n - 1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drives one command beat and waits until it is taken, then idles a random gap.
  task automatic send_command(cmd_row_t c);
    int gap;
    @(negedge clk_i);
    operation_i   <= c.op;
    src_node_i    <= c.src;
    dest_node_i   <= c.dst;
    edge_weight_i <= c.weight;
    start_node_i  <= c.start_node;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    apply_command(c);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Waits for the unit to drain, then writes the node count register.
  task automatic write_node_count(logic [6:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_paths.size() != 0) @(negedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (16) @(negedge clk_i);
    cfg_data_i <= value;
    cfg_valid  <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    node_count_q = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int pick;
    int n;
    n = active_count();
    pick = $urandom_range(0, 99);
    c.src = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, n - 1));
    c.dst = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, n - 1));
    c.weight = 12'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 60));
    c.start_node = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, n - 1));
    c.kind = EXP_MODEL;
    if (pick < 3) c.op = sssp_pkg::OP_CLEAR;
    else if (pick < 6) c.op = OP_NONE;
    else if (pick < 78) c.op = sssp_pkg::OP_ADD;
    else c.op = sssp_pkg::OP_RUN;
    return c;
  endfunction

  // Result checker: every strobed beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    path_res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_paths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat for node %0d", node_index_o);
      end else begin
        want = expected_paths.pop_front();
        if (node_index_o !== want.node || distance_o !== want.distance ||
            predecessor_o !== want.pred || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected node %0d dist %0d pred %0d last %0b,",
                     want.node, want.distance, $signed(want.pred), want.last);
            $display("  got node %0d dist %0d pred %0d last %0b",
                     node_index_o, distance_o, predecessor_o, last_o);
          end
        end
      end
    end
  end

  // The first run sees the edge store straight out of reset.
  cmd_row_t directed [] = '{
    '{sssp_pkg::OP_RUN,   6'd0,  6'd0,  12'd0,    6'd0,  EXP_ISOLATED},
    '{sssp_pkg::OP_CLEAR, 6'd0,  6'd0,  12'd0,    6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd0,  6'd1,  12'd0,    6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd1,  6'd2,  12'd4095, 6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd2,  6'd3,  12'd100,  6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd3,  6'd3,  12'd7,    6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd0,  6'd2,  12'd4095, 6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd2,  6'd0,  12'd10,   6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd0,  6'd2,  12'd20,   6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd40, 6'd1,  12'd1,    6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd63, 6'd63, 12'd4095, 6'd63, EXP_MODEL},
    '{sssp_pkg::OP_ADD,   6'd31, 6'd4,  12'd2,    6'd0,  EXP_MODEL},
    '{OP_NONE,            6'd63, 6'd63, 12'd4095, 6'd63, EXP_MODEL},
    '{sssp_pkg::OP_RUN,   6'd0,  6'd0,  12'd0,    6'd0,  EXP_MODEL},
    '{sssp_pkg::OP_RUN,   6'd0,  6'd0,  12'd0,    6'd31, EXP_MODEL},
    '{sssp_pkg::OP_RUN,   6'd0,  6'd0,  12'd0,    6'd63, EXP_ISOLATED},
    '{sssp_pkg::OP_RUN,   6'd0,  6'd0,  12'd0,    6'd3,  EXP_MODEL}
  };

  initial begin
    cmd_row_t c;
    logic [6:0] counts [4] = '{7'd0, 7'd127, 7'd5, 7'd1};
    // The edge store comes out of reset with no edges.
    foreach (edge_store[i]) edge_store[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset node count.
    foreach (directed[i]) send_command(directed[i]);

    // Node count extremes and a small graph, each with a few runs.
    foreach (counts[k]) begin
      write_node_count(counts[k]);
      send_command('{sssp_pkg::OP_RUN, 6'd0, 6'd0, 12'd0, 6'd0, EXP_MODEL});
      send_command('{sssp_pkg::OP_RUN, 6'd0, 6'd0, 12'd0, 6'd4, EXP_MODEL});
      send_command('{sssp_pkg::OP_RUN, 6'd0, 6'd0, 12'd0, 6'd5, EXP_MODEL});
    end

    // Random phases at freshly drawn node counts, the last one at 32.
    for (int p = 0; p < 4; p++) begin
      write_node_count((p == 3) ? 7'd32 : 7'($urandom_range(0, 127)));
      for (int i = 0; i < 20; i++) begin
        c = random_command();
        send_command(c);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && expected_paths.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/sssp_pkg.sv
sv/sssp_ram.sv
sv/sssp_ctrl.sv
sv/sssp_dp.sv
sv/single_source_shortest_path_unit.sv
sim/testbench.sv
